// ===== design/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared opcodes, function codes and the execute result type of the RV32I
// instruction execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;

    // data memory size in address bits (byte addressed)
    localparam int MEM_ADDR_BITS = 12;
    localparam int ROW_BITS      = MEM_ADDR_BITS - 2;

    // major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // load widths
    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_W  = 3'd2;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;

    // store sizes
    localparam logic [1:0] SZ_B = 2'd0;
    localparam logic [1:0] SZ_H = 2'd1;
    localparam logic [1:0] SZ_W = 2'd2;

    // branch conditions
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // alu functions
    localparam logic [2:0] AF_ADD  = 3'd0;
    localparam logic [2:0] AF_SLL  = 3'd1;
    localparam logic [2:0] AF_SLT  = 3'd2;
    localparam logic [2:0] AF_SLTU = 3'd3;
    localparam logic [2:0] AF_XOR  = 3'd4;
    localparam logic [2:0] AF_SR   = 3'd5;
    localparam logic [2:0] AF_OR   = 3'd6;
    localparam logic [2:0] AF_AND  = 3'd7;

    // result of the execute stage for one instruction
    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        is_load;
        logic [2:0]  ld_f3;
        logic        mw;
        logic [31:0] maddr;
        logic [1:0]  msize;
        logic [31:0] mdata;
    } t_exec_res;

endpackage

// ===== design/rvx_ram.sv =====
// ----------------------------------------------------------------------------
// rvx_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rvx_dmem.sv =====
// ----------------------------------------------------------------------------
// rvx_dmem
// Byte addressed little-endian data memory built from four byte lanes, so a
// misaligned or wrapping access of up to four bytes needs only one access to each lane.
// ----------------------------------------------------------------------------
module rvx_dmem import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rd_en,
    input  logic [31:0] i_rd_addr,
    input  logic        i_wr_en,
    input  logic [31:0] i_wr_addr,
    input  logic [1:0]  i_wr_size,
    input  logic [31:0] i_wr_data,
    output logic [31:0] o_rd_lanes
);

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]          rd_ofs;
        logic [1:0]          wr_ofs;
        logic [31:0]         rd_sum;
        logic [31:0]         wr_sum;
        logic                we;
        logic [7:0]          wbyte;
        logic [31:0]         wshift;

        // byte offset within the access that lands on this lane
        always_comb begin
            rd_ofs = 2'(l) - i_rd_addr[1:0];
            wr_ofs = 2'(l) - i_wr_addr[1:0];
            rd_sum = i_rd_addr + {30'd0, rd_ofs};
            wr_sum = i_wr_addr + {30'd0, wr_ofs};
            wshift = i_wr_data >> {wr_ofs, 3'b000};
            wbyte  = wshift[7:0];
            case (i_wr_size)
                SZ_B:    we = i_wr_en && (wr_ofs == 2'd0);
                SZ_H:    we = i_wr_en && !wr_ofs[1];
                SZ_W:    we = i_wr_en;
                default: we = 1'b0;
            endcase
        end

        rvx_ram #(
            .ADDR_BITS(ROW_BITS),
            .DATA_BITS(8)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(wr_sum[MEM_ADDR_BITS-1:2]),
            .i_wdata(wbyte),
            .i_re   (i_rd_en),
            .i_raddr(rd_sum[MEM_ADDR_BITS-1:2]),
            .o_rdata(o_rd_lanes[8*l +: 8])
        );
    end

endmodule

// ===== design/rvx_exec.sv =====
// ----------------------------------------------------------------------------
// rvx_exec
// Decode, immediate generation, ALU, branch compare and next pc for one
// instruction.
// ----------------------------------------------------------------------------
module rvx_exec import rvx_pkg::*; (
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_rs1_val,
    input  logic [31:0] i_rs2_val,
    output t_exec_res   o_res
);

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [31:0] a, b, alu_b, alu_y, pc4;
    logic [6:0]  alt;
    logic        is_imm, take, lt_s, lt_u;
    logic [4:0]  sh;

    // field and immediate extraction
    always_comb begin
        op    = i_instr[6:0];
        rd    = i_instr[11:7];
        f3    = i_instr[14:12];
        f7    = i_instr[31:25];
        imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
        imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
        imm_b = {{20{i_instr[31]}}, i_instr[7], i_instr[30:25], i_instr[11:8], 1'b0};
        imm_j = {{12{i_instr[31]}}, i_instr[19:12], i_instr[20], i_instr[30:21], 1'b0};
        imm_u = {i_instr[31:12], 12'd0};
        a     = i_rs1_val;
        b     = i_rs2_val;
        pc4   = i_pc + 32'd4;
        lt_s  = $signed(a) < $signed(b);
        lt_u  = a < b;
    end

    // alu operand selection, shared by OP and OP-IMM
    always_comb begin
        is_imm = (op == OPC_OPIMM);
        if (is_imm) begin
            alt   = ((f3 == AF_SLL) || (f3 == AF_SR)) ? f7 : F7_BASE;
            alu_b = ((f3 == AF_SLL) || (f3 == AF_SR)) ? {27'd0, imm_i[4:0]} : imm_i;
        end else begin
            alt   = f7;
            alu_b = b;
        end
        sh = alu_b[4:0];
        case (f3)
            AF_ADD: begin
                if (is_imm || alt == F7_BASE) alu_y = a + alu_b;
                else if (alt == F7_ALT)       alu_y = a - alu_b;
                else                          alu_y = 32'd0;
            end
            AF_SLL:  alu_y = (alt == F7_BASE) ? (a << sh) : 32'd0;
            AF_SLT:  alu_y = (is_imm || alt == F7_BASE) ?
                             {31'd0, $signed(a) < $signed(alu_b)} : 32'd0;
            AF_SLTU: alu_y = (is_imm || alt == F7_BASE) ? {31'd0, a < alu_b} : 32'd0;
            AF_XOR:  alu_y = (is_imm || alt == F7_BASE) ? (a ^ alu_b) : 32'd0;
            AF_SR: begin
                if (alt == F7_BASE)     alu_y = a >> sh;
                else if (alt == F7_ALT) alu_y = 32'($signed(a) >>> sh);
                else                    alu_y = 32'd0;
            end
            AF_OR:   alu_y = (is_imm || alt == F7_BASE) ? (a | alu_b) : 32'd0;
            AF_AND:  alu_y = (is_imm || alt == F7_BASE) ? (a & alu_b) : 32'd0;
            default: alu_y = 32'd0;
        endcase
    end

    // branch condition
    always_comb begin
        case (f3)
            BR_EQ:   take = (a == b);
            BR_NE:   take = (a != b);
            BR_LT:   take = lt_s;
            BR_GE:   take = !lt_s;
            BR_LTU:  take = lt_u;
            BR_GEU:  take = !lt_u;
            default: take = 1'b0;
        endcase
    end

    // per-opcode result
    always_comb begin
        o_res         = '0;
        o_res.npc     = pc4;
        o_res.rd      = rd;
        o_res.ld_f3   = f3;
        case (op)
            OPC_LUI: begin
                o_res.wr  = 1'b1;
                o_res.val = imm_u;
            end
            OPC_AUIPC: begin
                o_res.wr  = 1'b1;
                o_res.val = i_pc + imm_u;
            end
            OPC_JAL: begin
                o_res.wr  = 1'b1;
                o_res.val = pc4;
                o_res.npc = i_pc + imm_j;
            end
            OPC_JALR: begin
                o_res.wr  = 1'b1;
                o_res.val = pc4;
                o_res.npc = (a + imm_i) & ~32'd1;
            end
            OPC_BRANCH: begin
                if (take) o_res.npc = i_pc + imm_b;
            end
            OPC_LOAD: begin
                o_res.wr      = 1'b1;
                o_res.maddr   = a + imm_i;
                o_res.is_load = (f3 == LD_B) || (f3 == LD_H) || (f3 == LD_W) ||
                                (f3 == LD_BU) || (f3 == LD_HU);
            end
            OPC_STORE: begin
                o_res.maddr = a + imm_s;
                if (f3[2:0] <= 3'd2) begin
                    o_res.mw    = 1'b1;
                    o_res.msize = f3[1:0];
                    o_res.mdata = b;
                end
            end
            OPC_OP, OPC_OPIMM: begin
                o_res.wr  = 1'b1;
                o_res.val = alu_y;
            end
            default: ;
        endcase
        // writes to x0 are dropped and reported as none
        if (!(o_res.wr && rd != 5'd0)) begin
            o_res.wr      = 1'b0;
            o_res.rd      = 5'd0;
            o_res.val     = 32'd0;
            o_res.is_load = 1'b0;
        end
    end

endmodule

// ===== design/rv32i_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_execute
// RV32I instruction executor with register file, pc and byte data memory.
// ----------------------------------------------------------------------------
// One instruction is accepted per clock and one report leaves per clock,
// unless a report is stalled at the output. An instruction passes three
// registers: the input register, where it is decoded and executed and where
// stores write and loads read the four byte lanes of the data memory; the
// writeback register, where load data is aligned and the register file is
// written (and forwarded back to the next instruction); and the output
// register. While a report waits at the output the whole pipe holds,
// including the input. The data memory holds 2^MEM_ADDR_BITS bytes and is
// not cleared at reset; the register file, pc and count are.
module rv32i_instruction_execute import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pc_executed,
    output logic [31:0] o_pc_next,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_mem_write,
    output logic [31:0] o_mem_addr,
    output logic [1:0]  o_mem_size,
    output logic [31:0] o_mem_data,
    output logic [31:0] o_instr_count
);

    logic        en;
    logic        r_a_vld, r_b_vld, r_c_vld;
    logic [31:0] r_a_instr;
    logic [31:0] r_pc, r_cnt;
    logic [31:0] r_rf [32];
    t_exec_res   ex_res, wb_res, r_b_res, r_c_res;
    logic [31:0] r_b_pc, r_b_cnt, r_c_pc, r_c_cnt;
    logic [31:0] rs1_val, rs2_val, lanes, ld_word, b_val;
    logic [4:0]  rs1, rs2;
    logic [1:0]  ofs;
    logic [7:0]  ld_byte [4];
    logic        a_go, fwd1, fwd2;

    // the whole pipe moves unless a report is stalled at the output
    assign en         = !r_c_vld || i_out_ready;
    assign o_in_ready = en;
    assign a_go       = en && r_a_vld;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
        end
        if (en) begin
            r_a_instr <= i_instr;
        end
    end

    // operand read with forwarding from writeback
    always_comb begin
        rs1     = r_a_instr[19:15];
        rs2     = r_a_instr[24:20];
        fwd1    = r_b_vld && r_b_res.wr && (r_b_res.rd == rs1);
        fwd2    = r_b_vld && r_b_res.wr && (r_b_res.rd == rs2);
        rs1_val = fwd1 ? b_val : r_rf[rs1];
        rs2_val = fwd2 ? b_val : r_rf[rs2];
    end

    rvx_exec u_exec (
        .i_instr  (r_a_instr),
        .i_pc     (r_pc),
        .i_rs1_val(rs1_val),
        .i_rs2_val(rs2_val),
        .o_res    (ex_res)
    );

    rvx_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rd_en   (a_go && ex_res.is_load),
        .i_rd_addr (ex_res.maddr),
        .i_wr_en   (a_go && ex_res.mw),
        .i_wr_addr (ex_res.maddr),
        .i_wr_size (ex_res.msize),
        .i_wr_data (ex_res.mdata),
        .o_rd_lanes(lanes)
    );

    // pc and instruction count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= 32'd0;
            r_cnt <= 32'd0;
        end else if (a_go) begin
            r_pc  <= ex_res.npc;
            r_cnt <= r_cnt + 32'd1;
        end
    end

    // writeback register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
        if (en) begin
            r_b_res <= ex_res;
            r_b_pc  <= r_pc;
            r_b_cnt <= r_cnt;
        end
    end

    // load data alignment and extension, lane index wraps within the word
    always_comb begin
        ofs = r_b_res.maddr[1:0];
        for (int i = 0; i < 4; i++) begin
            ld_byte[i] = lanes[{2'(2'(i) + ofs), 3'b000} +: 8];
        end
        ld_word = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
        case (r_b_res.ld_f3)
            LD_B:    b_val = {{24{ld_word[7]}}, ld_word[7:0]};
            LD_H:    b_val = {{16{ld_word[15]}}, ld_word[15:0]};
            LD_W:    b_val = ld_word;
            LD_BU:   b_val = {24'd0, ld_word[7:0]};
            LD_HU:   b_val = {16'd0, ld_word[15:0]};
            default: b_val = 32'd0;
        endcase
        if (!r_b_res.is_load) begin
            b_val = r_b_res.val;
        end
    end

    // writeback result with the final register value
    always_comb begin
        wb_res     = r_b_res;
        wb_res.val = b_val;
    end

    // register file, x0 is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_rf[i] <= 32'd0;
            end
        end else if (en && r_b_vld && r_b_res.wr) begin
            r_rf[r_b_res.rd] <= b_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
        if (en) begin
            r_c_res <= wb_res;
            r_c_pc  <= r_b_pc;
            r_c_cnt <= r_b_cnt;
        end
    end

    assign o_out_valid   = r_c_vld;
    assign o_pc_executed = r_c_pc;
    assign o_pc_next     = r_c_res.npc;
    assign o_reg_write   = r_c_res.wr;
    assign o_reg_index   = r_c_res.rd;
    assign o_reg_value   = r_c_res.val;
    assign o_mem_write   = r_c_res.mw;
    assign o_mem_addr    = r_c_res.maddr;
    assign o_mem_size    = r_c_res.msize;
    assign o_mem_data    = r_c_res.mdata;
    assign o_instr_count = r_c_cnt;

    // pc and count run one ahead of the instruction in writeback
    a_pc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> r_pc == r_b_res.npc)
        else $error("pc does not follow writeback instruction");

    a_cnt_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> r_cnt == r_b_cnt + 32'd1)
        else $error("instruction count does not follow writeback");

    // a register write never targets x0
    a_no_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_res.wr) |-> r_b_res.rd != 5'd0)
        else $error("register write to x0");

    // a store reports a legal size
    a_store_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mem_write) |-> o_mem_size != 2'd3)
        else $error("illegal store size");

endmodule
